// ===== rtl/acpiec_pkg.sv =====
// Shared types, codes and reset constants for the EC host transaction engine.
// No dependencies; imported by every module of the block.
package acpiec_pkg;

    localparam logic [15:0] CMD_PORT_RST  = 16'h0066;
    localparam logic [15:0] DATA_PORT_RST = 16'h0062;
    localparam logic [15:0] POLL_LIM_RST  = 16'd500;
    localparam logic [7:0]  MAX_ATT_RST   = 8'd5;
    localparam logic [7:0]  SKIP_THR_RST  = 8'd20;

    localparam logic [7:0]  ST_OBF = 8'h01;
    localparam logic [7:0]  ST_IBF = 8'h02;
    localparam logic [7:0]  CMD_RD = 8'h80;
    localparam logic [7:0]  CMD_WR = 8'h81;

    localparam logic [8:0]  RFC_MAX = 9'd256;

    typedef enum logic [2:0] {
        REQ_RD_BYTE = 3'd0,
        REQ_RD_WORD = 3'd1,
        REQ_WR_BYTE = 3'd2,
        REQ_WR_WORD = 3'd3,
        REQ_PORT_RSP = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        CFG_CMD_PORT  = 3'd0,
        CFG_DATA_PORT = 3'd1,
        CFG_POLL_LIM  = 3'd2,
        CFG_MAX_ATT   = 3'd3,
        CFG_SKIP_THR  = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_PORT_RD = 2'd0,
        ACT_PORT_WR = 2'd1,
        ACT_DONE    = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_WAIT_CMD = 4'd1,
        PH_CMD_WR   = 4'd2,
        PH_WAIT_ADR = 4'd3,
        PH_ADR_WR   = 4'd4,
        PH_WAIT_DAT = 4'd5,
        PH_DAT_WR   = 4'd6,
        PH_WAIT_OBF = 4'd7,
        PH_DAT_RD   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [15:0] cmd_port_addr;
        logic [15:0] data_port_addr;
        logic [15:0] poll_limit;
        logic [7:0]  max_attempts;
        logic [7:0]  skip_threshold;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  reg_addr;
        logic [15:0] wr_data;
        logic        port_ok;
        logic [7:0]  port_rdata;
    } item_t;

    typedef struct packed {
        logic [1:0]  act;
        logic [15:0] port_addr;
        logic [7:0]  port_wdata;
        logic        ok;
        logic [15:0] rd_value;
    } result_t;

endpackage

// ===== rtl/acpiec_cfg.sv =====
// Configuration register file for the EC host transaction engine.
// Depends on acpiec_pkg for the register layout and reset values.
module acpiec_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [15:0]         wr_data,
    output acpiec_pkg::cfg_t    cfg
);
    import acpiec_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_CMD_PORT:  cfg_next.cmd_port_addr  = wr_data;
                CFG_DATA_PORT: cfg_next.data_port_addr = wr_data;
                CFG_POLL_LIM:  cfg_next.poll_limit     = wr_data;
                CFG_MAX_ATT:   cfg_next.max_attempts   = wr_data[7:0];
                CFG_SKIP_THR:  cfg_next.skip_threshold = wr_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd_port_addr  <= CMD_PORT_RST;
            cfg_reg.data_port_addr <= DATA_PORT_RST;
            cfg_reg.poll_limit     <= POLL_LIM_RST;
            cfg_reg.max_attempts   <= MAX_ATT_RST;
            cfg_reg.skip_threshold <= SKIP_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/acpiec_engine.sv =====
// Request state machine: phase, retry and poll counters, and the result of one transaction.
// Depends on acpiec_pkg for phase codes, item and result structs.
module acpiec_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  acpiec_pkg::item_t    item,
    input  acpiec_pkg::cfg_t     cfg,
    output logic                 res_valid,
    output acpiec_pkg::result_t  res
);
    import acpiec_pkg::*;

    phase_t      phase_reg,      phase_next;
    logic [1:0]  op_kind_reg,    op_kind_next;
    logic [7:0]  cur_addr_reg,   cur_addr_next;
    logic [15:0] write_word_reg, write_word_next;
    logic        byte_sel_reg,   byte_sel_next;
    logic [15:0] spin_reg,       spin_next;
    logic [7:0]  attempts_reg,   attempts_next;
    logic [8:0]  rfc_reg,        rfc_next;
    logic [7:0]  low_byte_reg,   low_byte_next;

    always_comb
    begin
        logic        do_enter;
        logic        do_fail;
        logic        do_finish;
        logic        do_bdone;
        logic        fin_ok;
        logic [15:0] fin_val;
        logic [7:0]  bd_data;
        phase_t      ent_ph;
        logic        met;
        logic [15:0] spin_inc;
        logic [7:0]  att_dec;

        phase_next      = phase_reg;
        op_kind_next    = op_kind_reg;
        cur_addr_next   = cur_addr_reg;
        write_word_next = write_word_reg;
        byte_sel_next   = byte_sel_reg;
        spin_next       = spin_reg;
        attempts_next   = attempts_reg;
        rfc_next        = rfc_reg;
        low_byte_next   = low_byte_reg;
        res_valid       = 1'b0;
        res             = '0;
        do_enter        = 1'b0;
        do_fail         = 1'b0;
        do_finish       = 1'b0;
        do_bdone        = 1'b0;
        fin_ok          = 1'b0;
        fin_val         = '0;
        bd_data         = '0;
        ent_ph          = PH_WAIT_CMD;
        met             = 1'b0;
        spin_inc        = spin_reg + 16'd1;
        att_dec         = '0;

        if (step)
        begin
            if (item.req_type <= REQ_WR_WORD)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    op_kind_next    = item.req_type[1:0];
                    cur_addr_next   = item.reg_addr;
                    write_word_next = item.wr_data;
                    byte_sel_next   = 1'b0;
                    attempts_next   = cfg.max_attempts;
                    if (cfg.max_attempts == 8'd0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        do_enter = 1'b1;
                        ent_ph   = PH_WAIT_CMD;
                    end
                end
            end
            else if (item.req_type == REQ_PORT_RSP && phase_reg != PH_IDLE)
            begin
                unique case (phase_reg)
                    PH_WAIT_CMD, PH_WAIT_ADR, PH_WAIT_DAT, PH_WAIT_OBF:
                    begin
                        if (phase_reg == PH_WAIT_OBF)
                            met = item.port_ok && ((item.port_rdata & ST_OBF) != 8'd0);
                        else
                            met = item.port_ok && ((item.port_rdata & ST_IBF) == 8'd0);
                        if (met)
                        begin
                            do_enter = 1'b1;
                            unique case (phase_reg)
                                PH_WAIT_CMD: ent_ph = PH_CMD_WR;
                                PH_WAIT_ADR: ent_ph = PH_ADR_WR;
                                PH_WAIT_DAT: ent_ph = op_kind_reg[1] ? PH_DAT_WR : PH_WAIT_OBF;
                                default:
                                begin
                                    rfc_next = '0;
                                    ent_ph   = PH_DAT_RD;
                                end
                            endcase
                        end
                        else
                        begin
                            spin_next = spin_inc;
                            if (spin_inc >= cfg.poll_limit || spin_inc == 16'd0)
                            begin
                                if (phase_reg == PH_WAIT_OBF && rfc_reg < RFC_MAX)
                                    rfc_next = rfc_reg + 9'd1;
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                res_valid     = 1'b1;
                                res.act       = ACT_PORT_RD;
                                res.port_addr = cfg.cmd_port_addr;
                            end
                        end
                    end
                    PH_CMD_WR:
                    begin
                        do_enter = item.port_ok;
                        ent_ph   = PH_WAIT_ADR;
                        do_fail  = !item.port_ok;
                    end
                    PH_ADR_WR:
                    begin
                        do_enter = item.port_ok;
                        ent_ph   = PH_WAIT_DAT;
                        do_fail  = !item.port_ok;
                    end
                    PH_DAT_WR:
                    begin
                        do_bdone = item.port_ok;
                        bd_data  = '0;
                        do_fail  = !item.port_ok;
                    end
                    PH_DAT_RD:
                    begin
                        do_bdone = item.port_ok;
                        bd_data  = item.port_rdata;
                        do_fail  = !item.port_ok;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        // retry the whole request or give up
        if (do_fail)
        begin
            att_dec = (attempts_reg != 8'd0) ? attempts_reg - 8'd1 : attempts_reg;
            attempts_next = att_dec;
            if (att_dec == 8'd0)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                byte_sel_next = 1'b0;
                do_enter      = 1'b1;
                ent_ph        = PH_WAIT_CMD;
            end
        end

        // advance to the next byte or complete
        if (do_bdone)
        begin
            if (op_kind_reg[0] && !byte_sel_reg)
            begin
                if (!op_kind_reg[1])
                    low_byte_next = bd_data;
                byte_sel_next = 1'b1;
                do_enter      = 1'b1;
                ent_ph        = PH_WAIT_CMD;
            end
            else
            begin
                do_finish = 1'b1;
                fin_ok    = 1'b1;
                if (op_kind_reg[1])
                    fin_val = '0;
                else if (op_kind_reg[0])
                    fin_val = {bd_data, low_byte_reg};
                else
                    fin_val = {8'd0, bd_data};
            end
        end

        if (do_enter)
        begin
            if (ent_ph == PH_WAIT_OBF && rfc_next > {1'b0, cfg.skip_threshold})
                ent_ph = PH_DAT_RD;
            phase_next    = ent_ph;
            spin_next     = '0;
            res_valid     = 1'b1;
            unique case (ent_ph)
                PH_CMD_WR:
                begin
                    res.act        = ACT_PORT_WR;
                    res.port_addr  = cfg.cmd_port_addr;
                    res.port_wdata = op_kind_next[1] ? CMD_WR : CMD_RD;
                end
                PH_ADR_WR:
                begin
                    res.act        = ACT_PORT_WR;
                    res.port_addr  = cfg.data_port_addr;
                    res.port_wdata = cur_addr_next + {7'd0, byte_sel_next};
                end
                PH_DAT_WR:
                begin
                    res.act        = ACT_PORT_WR;
                    res.port_addr  = cfg.data_port_addr;
                    res.port_wdata = byte_sel_next ? write_word_next[15:8]
                                                   : write_word_next[7:0];
                end
                PH_DAT_RD:
                begin
                    res.act       = ACT_PORT_RD;
                    res.port_addr = cfg.data_port_addr;
                end
                default:
                begin
                    res.act       = ACT_PORT_RD;
                    res.port_addr = cfg.cmd_port_addr;
                end
            endcase
        end

        if (do_finish)
        begin
            phase_next   = PH_IDLE;
            res_valid    = 1'b1;
            res          = '0;
            res.act      = ACT_DONE;
            res.ok       = fin_ok;
            res.rd_value = fin_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            op_kind_reg    <= '0;
            cur_addr_reg   <= '0;
            write_word_reg <= '0;
            byte_sel_reg   <= 1'b0;
            spin_reg       <= '0;
            attempts_reg   <= '0;
            rfc_reg        <= '0;
            low_byte_reg   <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            op_kind_reg    <= op_kind_next;
            cur_addr_reg   <= cur_addr_next;
            write_word_reg <= write_word_next;
            byte_sel_reg   <= byte_sel_next;
            spin_reg       <= spin_next;
            attempts_reg   <= attempts_next;
            rfc_reg        <= rfc_next;
            low_byte_reg   <= low_byte_next;
        end
    end

endmodule

// ===== rtl/acpi_ec_host_transaction_engine.sv =====
// EC host transaction engine top level: input register, state machine, result register.
// Depends on acpiec_pkg, acpiec_cfg and acpiec_engine.
// A held transaction is processed when the result slot is free or draining; its result
// is registered. Throughput: one transaction per cycle when the result slot is free or
// draining; the state machine's phase and counter update between the registers sets it.
// Reset: asynchronous, clears control state and loads the register defaults.
module acpi_ec_host_transaction_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] wr_data,
    input  logic        port_ok,
    input  logic [7:0]  port_rdata,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  act,
    output logic [15:0] port_addr,
    output logic [7:0]  port_wdata,
    output logic        ok,
    output logic [15:0] rd_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import acpiec_pkg::*;

    cfg_t    cfg;
    item_t   item_reg,  item_next;
    logic    ivalid_reg, ivalid_next;
    result_t res;
    logic    res_valid;
    result_t out_reg,   out_next;
    logic    ovalid_reg, ovalid_next;
    logic    advance;

    assign cfg_ready = 1'b1;

    acpiec_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // process the held transaction when the result slot is free or draining
    assign advance  = ivalid_reg && (!ovalid_reg || out_ready);
    assign in_ready = !ivalid_reg || advance;

    acpiec_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        item_next   = item_reg;
        ivalid_next = ivalid_reg;
        if (in_valid && in_ready)
        begin
            item_next.req_type   = req_type;
            item_next.reg_addr   = reg_addr;
            item_next.wr_data    = wr_data;
            item_next.port_ok    = port_ok;
            item_next.port_rdata = port_rdata;
            ivalid_next          = 1'b1;
        end
        else if (advance)
        begin
            ivalid_next = 1'b0;
        end

        out_next    = out_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (advance && res_valid)
        begin
            out_next    = res;
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ivalid_reg <= ivalid_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign out_valid  = ovalid_reg;
    assign act        = out_reg.act;
    assign port_addr  = out_reg.port_addr;
    assign port_wdata = out_reg.port_wdata;
    assign ok         = out_reg.ok;
    assign rd_value   = out_reg.rd_value;

endmodule
